FILE: src/poi_pkg.sv
// shared types, constants and tables of the planar odometry integrator
package poi_pkg;

  localparam int CORDIC_ITERATIONS_DEFAULT = 16;
  localparam int ANGLE_BITS_DEFAULT        = 16;

  localparam logic [15:0] GAIN_RESET = 16'd9011;

  // program counter of the sequencer
  localparam int STEP_W = 5;

  // shared multiplier and accumulator widths
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 21;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 1;

  // rotator: x and y in Q2.30 with headroom, angle residue one bit wider than a turn
  localparam int CR_XY_W     = 34;
  localparam int CR_Z_W      = 33;
  localparam int ATAN_IDX_W  = 5;
  localparam logic signed [CR_XY_W-1:0] CORDIC_K = 34'sd652032874;
  localparam logic signed [CR_XY_W-1:0] ONE_Q30  = 34'sd1073741824;

  // arctangent of 2^-i, 2^32 per turn, padded with zeros to a power of two
  localparam logic [31:0] ATAN_TAB [2**ATAN_IDX_W] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
  };

  typedef enum logic [3:0] {
    MUL_GAIN_VX,
    MUL_WZ_DT,
    MUL_C_VXS,
    MUL_S_VY,
    MUL_S_VXS,
    MUL_C_VY,
    MUL_VW_DT,
    MUL_QUAT_C,
    MUL_QUAT_S
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [2:0] {
    RND_12,
    RND_15,
    RND_20,
    RND_24,
    RND_HEAD
  } rnd_sel_t;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_VXS,
    WB_VW,
    WB_POS_X,
    WB_POS_Y,
    WB_HEAD,
    WB_QUAT_Z,
    WB_QUAT_W
  } wb_sel_t;

  typedef enum logic [1:0] {
    CS_NONE,
    CS_HEADING,
    CS_HALF
  } cstart_t;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_NO_INPUT,
    COND_CORDIC_BUSY,
    COND_OUT_FULL
  } cond_t;

  typedef struct packed {
    logic              take;
    cstart_t           cstart;
    logic              capture;
    mul_sel_t          mul;
    acc_op_t           acc;
    rnd_sel_t          rnd;
    wb_sel_t           wb;
    logic              emit;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } cw_t;

  typedef struct packed {
    logic in_valid;
    logic cordic_busy;
    logic out_full;
  } stat_t;

  localparam cw_t CW_NOP = '{
    take:    1'b0,
    cstart:  CS_NONE,
    capture: 1'b0,
    mul:     MUL_GAIN_VX,
    acc:     ACC_HOLD,
    rnd:     RND_12,
    wb:      WB_NONE,
    emit:    1'b0,
    cond:    COND_NEVER,
    target:  '0
  };

endpackage

FILE: src/poi_seq.sv
// microprogram store, step counter and jump logic
module poi_seq (
  input  logic            clk,
  input  logic            rst,
  input  poi_pkg::stat_t  stat,
  output poi_pkg::cw_t    cw
);

  localparam logic [poi_pkg::STEP_W-1:0] ST_IDLE    = 5'd0;
  localparam logic [poi_pkg::STEP_W-1:0] ST_GAIN    = 5'd1;
  localparam logic [poi_pkg::STEP_W-1:0] ST_YAWMUL  = 5'd2;
  localparam logic [poi_pkg::STEP_W-1:0] ST_VXS     = 5'd3;
  localparam logic [poi_pkg::STEP_W-1:0] ST_HEAD    = 5'd4;
  localparam logic [poi_pkg::STEP_W-1:0] ST_WAIT_C1 = 5'd5;
  localparam logic [poi_pkg::STEP_W-1:0] ST_CAPTURE = 5'd6;
  localparam logic [poi_pkg::STEP_W-1:0] ST_MX0     = 5'd7;
  localparam logic [poi_pkg::STEP_W-1:0] ST_MX1     = 5'd8;
  localparam logic [poi_pkg::STEP_W-1:0] ST_MX2     = 5'd9;
  localparam logic [poi_pkg::STEP_W-1:0] ST_VWX     = 5'd10;
  localparam logic [poi_pkg::STEP_W-1:0] ST_MY2     = 5'd11;
  localparam logic [poi_pkg::STEP_W-1:0] ST_VWY     = 5'd12;
  localparam logic [poi_pkg::STEP_W-1:0] ST_POSX    = 5'd13;
  localparam logic [poi_pkg::STEP_W-1:0] ST_DTY     = 5'd14;
  localparam logic [poi_pkg::STEP_W-1:0] ST_POSY    = 5'd15;
  localparam logic [poi_pkg::STEP_W-1:0] ST_WAIT_C2 = 5'd16;
  localparam logic [poi_pkg::STEP_W-1:0] ST_QMUL_C  = 5'd17;
  localparam logic [poi_pkg::STEP_W-1:0] ST_QMUL_S  = 5'd18;
  localparam logic [poi_pkg::STEP_W-1:0] ST_QW      = 5'd19;
  localparam logic [poi_pkg::STEP_W-1:0] ST_QZ      = 5'd20;
  localparam logic [poi_pkg::STEP_W-1:0] ST_EMIT    = 5'd21;

  logic [poi_pkg::STEP_W-1:0] step;
  logic [poi_pkg::STEP_W-1:0] step_next;
  logic                       jump;

  // product is registered in prod, then taken by acc, which the writeback reads
  function automatic poi_pkg::cw_t rom_word(input logic [poi_pkg::STEP_W-1:0] s);
    poi_pkg::cw_t w;
    w = poi_pkg::CW_NOP;
    unique case (s)
      ST_IDLE: begin
        w.take   = 1'b1;
        w.cond   = poi_pkg::COND_NO_INPUT;
        w.target = ST_IDLE;
      end
      ST_GAIN: begin
        w.cstart = poi_pkg::CS_HEADING;
        w.mul    = poi_pkg::MUL_GAIN_VX;
      end
      ST_YAWMUL: begin
        w.acc = poi_pkg::ACC_LOAD;
        w.mul = poi_pkg::MUL_WZ_DT;
      end
      ST_VXS: begin
        w.rnd = poi_pkg::RND_12;
        w.wb  = poi_pkg::WB_VXS;
        w.acc = poi_pkg::ACC_LOAD;
      end
      ST_HEAD: begin
        w.rnd = poi_pkg::RND_HEAD;
        w.wb  = poi_pkg::WB_HEAD;
      end
      ST_WAIT_C1: begin
        w.cond   = poi_pkg::COND_CORDIC_BUSY;
        w.target = ST_WAIT_C1;
      end
      ST_CAPTURE: begin
        w.capture = 1'b1;
        w.cstart  = poi_pkg::CS_HALF;
      end
      ST_MX0: begin
        w.mul = poi_pkg::MUL_C_VXS;
      end
      ST_MX1: begin
        w.mul = poi_pkg::MUL_S_VY;
        w.acc = poi_pkg::ACC_LOAD;
      end
      ST_MX2: begin
        w.mul = poi_pkg::MUL_S_VXS;
        w.acc = poi_pkg::ACC_SUB;
      end
      ST_VWX: begin
        w.rnd = poi_pkg::RND_24;
        w.wb  = poi_pkg::WB_VW;
        w.acc = poi_pkg::ACC_LOAD;
        w.mul = poi_pkg::MUL_C_VY;
      end
      ST_MY2: begin
        w.acc = poi_pkg::ACC_ADD;
        w.mul = poi_pkg::MUL_VW_DT;
      end
      ST_VWY: begin
        w.rnd = poi_pkg::RND_24;
        w.wb  = poi_pkg::WB_VW;
        w.acc = poi_pkg::ACC_LOAD;
      end
      ST_POSX: begin
        w.rnd = poi_pkg::RND_20;
        w.wb  = poi_pkg::WB_POS_X;
        w.mul = poi_pkg::MUL_VW_DT;
      end
      ST_DTY: begin
        w.acc = poi_pkg::ACC_LOAD;
      end
      ST_POSY: begin
        w.rnd = poi_pkg::RND_20;
        w.wb  = poi_pkg::WB_POS_Y;
      end
      ST_WAIT_C2: begin
        w.cond   = poi_pkg::COND_CORDIC_BUSY;
        w.target = ST_WAIT_C2;
      end
      ST_QMUL_C: begin
        w.mul = poi_pkg::MUL_QUAT_C;
      end
      ST_QMUL_S: begin
        w.mul = poi_pkg::MUL_QUAT_S;
        w.acc = poi_pkg::ACC_LOAD;
      end
      ST_QW: begin
        w.rnd = poi_pkg::RND_15;
        w.wb  = poi_pkg::WB_QUAT_W;
        w.acc = poi_pkg::ACC_LOAD;
      end
      ST_QZ: begin
        w.rnd = poi_pkg::RND_15;
        w.wb  = poi_pkg::WB_QUAT_Z;
      end
      ST_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = poi_pkg::COND_OUT_FULL;
        w.target = ST_EMIT;
      end
      default: ;
    endcase
    return w;
  endfunction

  assign cw = rom_word(step);

  always_comb begin
    unique case (cw.cond)
      poi_pkg::COND_NEVER:       jump = 1'b0;
      poi_pkg::COND_NO_INPUT:    jump = !stat.in_valid;
      poi_pkg::COND_CORDIC_BUSY: jump = stat.cordic_busy;
      poi_pkg::COND_OUT_FULL:    jump = stat.out_full;
      default:                   jump = 1'b0;
    endcase
  end

  always_comb begin
    if (jump) begin
      step_next = cw.target;
    end else if (step == ST_EMIT) begin
      step_next = ST_IDLE;
    end else begin
      step_next = step + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

FILE: src/poi_cordic.sv
// iterative cordic rotator, one micro-rotation per cycle, sin and cos in Q2.30
module poi_cordic #(
  parameter int ITERATIONS = poi_pkg::CORDIC_ITERATIONS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               busy,
  output logic signed [31:0] cos_q,
  output logic signed [31:0] sin_q
);

  localparam logic [poi_pkg::ATAN_IDX_W-1:0] ITER_END = poi_pkg::ATAN_IDX_W'(ITERATIONS);

  logic signed [poi_pkg::CR_XY_W-1:0] x;
  logic signed [poi_pkg::CR_XY_W-1:0] y;
  logic signed [poi_pkg::CR_Z_W-1:0]  z;
  logic                               flip;
  logic [poi_pkg::ATAN_IDX_W-1:0]     iter;

  logic                               fold;
  logic [31:0]                        folded;
  logic signed [poi_pkg::CR_XY_W-1:0] xs;
  logic signed [poi_pkg::CR_XY_W-1:0] ys;
  logic [poi_pkg::CR_Z_W-1:0]         atan;
  logic signed [31:0]                 c_sat;
  logic signed [31:0]                 s_sat;

  function automatic logic signed [31:0] sat_q30(input logic signed [poi_pkg::CR_XY_W-1:0] v);
    logic signed [31:0] r;
    if (v > poi_pkg::ONE_Q30) begin
      r = 32'sh4000_0000;
    end else if (v < -poi_pkg::ONE_Q30) begin
      r = -32'sh4000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // second and third quadrant: rotate by half a turn and negate the result
  assign fold   = angle[31] ^ angle[30];
  assign folded = {angle[31] ^ fold, angle[30:0]};

  assign xs    = x >>> iter;
  assign ys    = y >>> iter;
  assign atan  = poi_pkg::CR_Z_W'(poi_pkg::ATAN_TAB[iter]);
  assign c_sat = sat_q30(x);
  assign s_sat = sat_q30(y);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= '0;
    end else if (busy) begin
      if (iter == ITER_END) begin
        busy <= 1'b0;
      end else begin
        iter <= iter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= poi_pkg::CORDIC_K;
      y    <= '0;
      z    <= poi_pkg::CR_Z_W'($signed(folded));
      flip <= fold;
    end else if (busy) begin
      if (iter != ITER_END) begin
        if (!z[poi_pkg::CR_Z_W-1]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - $signed(atan);
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + $signed(atan);
        end
      end else begin
        cos_q <= flip ? -c_sat : c_sat;
        sin_q <= flip ? -s_sat : s_sat;
      end
    end
  end

endmodule

FILE: src/poi_datapath.sv
// datapath: shared multiplier, accumulator, rounding writeback, pose state and result register
module poi_datapath #(
  parameter int ANGLE_BITS = poi_pkg::ANGLE_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  poi_pkg::cw_t       cw,
  input  logic               in_accept,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic signed [23:0] yaw_rate,
  input  logic [19:0]        elapsed,
  input  logic [15:0]        linear_gain,
  input  logic signed [31:0] cos_q,
  input  logic signed [31:0] sin_q,
  output logic [31:0]        angle,
  output logic               out_full,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [15:0]        heading_out,
  output logic signed [15:0] quat_z,
  output logic signed [15:0] quat_w,
  output logic signed [15:0] vel_x_scaled,
  output logic signed [15:0] vel_y_out,
  output logic signed [23:0] yaw_rate_out
);

  localparam int ACC_W = poi_pkg::ACC_W;
  localparam logic [4:0] HEAD_SHIFT = 5'(36 - ANGLE_BITS);
  localparam logic signed [ACC_W-1:0] S16_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] S16_MIN = ACC_W'(-32768);
  localparam logic signed [33:0] P_MAX = 34'sd2147483647;
  localparam logic signed [33:0] P_MIN = -34'sd2147483648;

  // latched tick
  logic signed [15:0] vx;
  logic signed [15:0] vy;
  logic signed [23:0] wz;
  logic [19:0]        dt;

  // working registers
  logic signed [15:0]                 vxs;
  logic signed [31:0]                 cap_c;
  logic signed [31:0]                 cap_s;
  logic signed [poi_pkg::MUL_A_W-1:0] vw;
  logic signed [poi_pkg::PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]            acc;
  logic signed [15:0]                 qz;
  logic signed [15:0]                 qw;

  // pose state
  logic signed [31:0]       acc_x;
  logic signed [31:0]       acc_y;
  logic [ANGLE_BITS-1:0]    heading;

  logic signed [poi_pkg::MUL_A_W-1:0] mul_a;
  logic signed [poi_pkg::MUL_B_W-1:0] mul_b;
  logic [4:0]                         sh;
  logic signed [ACC_W-1:0]            half;
  logic signed [ACC_W-1:0]            rnd;
  logic [31:0]                        a32;
  logic                               emit_fire;

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [15:0] r;
    if (v > S16_MAX) begin
      r = 16'sh7FFF;
    end else if (v < S16_MIN) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_pos(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > P_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < P_MIN) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // heading as a 32-bit binary angle
  assign a32   = 32'(heading) << (32 - ANGLE_BITS);
  assign angle = (cw.cstart == poi_pkg::CS_HALF) ? {1'b0, a32[31:1]} : a32;

  assign out_full  = out_valid && out_stall;
  assign emit_fire = cw.emit && !out_full;

  always_comb begin
    unique case (cw.mul)
      poi_pkg::MUL_GAIN_VX: begin
        mul_a = poi_pkg::MUL_A_W'($signed({1'b0, linear_gain}));
        mul_b = poi_pkg::MUL_B_W'(vx);
      end
      poi_pkg::MUL_WZ_DT: begin
        mul_a = poi_pkg::MUL_A_W'(wz);
        mul_b = $signed({1'b0, dt});
      end
      poi_pkg::MUL_C_VXS: begin
        mul_a = cap_c;
        mul_b = poi_pkg::MUL_B_W'(vxs);
      end
      poi_pkg::MUL_S_VY: begin
        mul_a = cap_s;
        mul_b = poi_pkg::MUL_B_W'(vy);
      end
      poi_pkg::MUL_S_VXS: begin
        mul_a = cap_s;
        mul_b = poi_pkg::MUL_B_W'(vxs);
      end
      poi_pkg::MUL_C_VY: begin
        mul_a = cap_c;
        mul_b = poi_pkg::MUL_B_W'(vy);
      end
      poi_pkg::MUL_VW_DT: begin
        mul_a = vw;
        mul_b = $signed({1'b0, dt});
      end
      poi_pkg::MUL_QUAT_C: begin
        mul_a = cos_q;
        mul_b = poi_pkg::MUL_B_W'(1);
      end
      poi_pkg::MUL_QUAT_S: begin
        mul_a = sin_q;
        mul_b = poi_pkg::MUL_B_W'(1);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // round half up, then arithmetic shift
  always_comb begin
    unique case (cw.rnd)
      poi_pkg::RND_12:   sh = 5'd12;
      poi_pkg::RND_15:   sh = 5'd15;
      poi_pkg::RND_20:   sh = 5'd20;
      poi_pkg::RND_24:   sh = 5'd24;
      poi_pkg::RND_HEAD: sh = HEAD_SHIFT;
      default:           sh = 5'd12;
    endcase
    half = ACC_W'(1) << (sh - 5'd1);
    rnd  = (acc + half) >>> sh;
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      vx <= vel_x;
      vy <= vel_y;
      wz <= yaw_rate;
      dt <= elapsed;
    end
    if (cw.capture) begin
      cap_c <= cos_q;
      cap_s <= sin_q;
    end
    prod <= mul_a * mul_b;
    unique case (cw.acc)
      poi_pkg::ACC_HOLD: acc <= acc;
      poi_pkg::ACC_LOAD: acc <= ACC_W'(prod);
      poi_pkg::ACC_ADD:  acc <= acc + ACC_W'(prod);
      poi_pkg::ACC_SUB:  acc <= acc - ACC_W'(prod);
      default:           acc <= acc;
    endcase
    unique case (cw.wb)
      poi_pkg::WB_VXS:    vxs <= sat16(rnd);
      poi_pkg::WB_VW:     vw  <= rnd[poi_pkg::MUL_A_W-1:0];
      poi_pkg::WB_QUAT_Z: qz  <= sat16(rnd);
      poi_pkg::WB_QUAT_W: qw  <= sat16(rnd);
      default: ;
    endcase
    if (emit_fire) begin
      pos_x        <= acc_x;
      pos_y        <= acc_y;
      heading_out  <= a32[31:16];
      quat_z       <= qz;
      quat_w       <= qw;
      vel_x_scaled <= vxs;
      vel_y_out    <= vy;
      yaw_rate_out <= wz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_x     <= '0;
      acc_y     <= '0;
      heading   <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (cw.wb)
        poi_pkg::WB_POS_X: acc_x   <= sat_pos(34'(acc_x) + rnd[33:0]);
        poi_pkg::WB_POS_Y: acc_y   <= sat_pos(34'(acc_y) + rnd[33:0]);
        poi_pkg::WB_HEAD:  heading <= heading + rnd[ANGLE_BITS-1:0];
        default: ;
      endcase
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: src/planar_odometry_integrator.sv
// top level of the planar odometry integrator: gain register, sequencer, rotator, datapath
//
// Usage
//   Ticks come in on in_valid/in_stall with vel_x, vel_y, yaw_rate and elapsed;
//   each tick gives exactly one result on out_valid/out_stall. A transfer
//   happens at a clock edge with valid high and stall low.
//   linear_gain is loaded by cfg_write/cfg_data. The user must load it only while
//   no tick is in progress; the block itself does not enforce this. A tick runs
//   from its input transfer to out_valid through the microprogram, and the next
//   tick is taken on the cycle the result appears, so ticks are handled one at
//   a time. The time each takes is set by the two passes through the single
//   iterative rotator (old heading for the position step, half the new heading
//   for the quaternion), with the microprogram feeding the one shared multiplier
//   in between.
//   The result sits in an output register: a stalled receiver does not hold up
//   the next tick, only its final hand-over, which waits for the register to free.
//   Reset (rst, synchronous) clears position and heading to zero, sets the gain
//   to 2.2 and leaves the block idle with no result pending.
module planar_odometry_integrator #(
  parameter int CORDIC_ITERATIONS = poi_pkg::CORDIC_ITERATIONS_DEFAULT,
  parameter int ANGLE_BITS        = poi_pkg::ANGLE_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic signed [23:0] yaw_rate,
  input  logic [19:0]        elapsed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [15:0]        heading_out,
  output logic signed [15:0] quat_z,
  output logic signed [15:0] quat_w,
  output logic signed [15:0] vel_x_scaled,
  output logic signed [15:0] vel_y_out,
  output logic signed [23:0] yaw_rate_out
);

  logic [15:0]        linear_gain;
  poi_pkg::cw_t       cw;
  poi_pkg::stat_t     stat;
  logic               in_accept;
  logic               cordic_start;
  logic               cordic_busy;
  logic [31:0]        angle;
  logic signed [31:0] cos_q;
  logic signed [31:0] sin_q;
  logic               out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      linear_gain <= poi_pkg::GAIN_RESET;
    end else if (cfg_write) begin
      linear_gain <= cfg_data;
    end
  end

  assign in_stall     = !cw.take;
  assign in_accept    = in_valid && !in_stall;
  assign cordic_start = (cw.cstart != poi_pkg::CS_NONE);

  assign stat.in_valid    = in_valid;
  assign stat.cordic_busy = cordic_busy;
  assign stat.out_full    = out_full;

  poi_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cw   (cw)
  );

  poi_cordic #(
    .ITERATIONS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .angle (angle),
    .busy  (cordic_busy),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  poi_datapath #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cw           (cw),
    .in_accept    (in_accept),
    .vel_x        (vel_x),
    .vel_y        (vel_y),
    .yaw_rate     (yaw_rate),
    .elapsed      (elapsed),
    .linear_gain  (linear_gain),
    .cos_q        (cos_q),
    .sin_q        (sin_q),
    .angle        (angle),
    .out_full     (out_full),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .heading_out  (heading_out),
    .quat_z       (quat_z),
    .quat_w       (quat_w),
    .vel_x_scaled (vel_x_scaled),
    .vel_y_out    (vel_y_out),
    .yaw_rate_out (yaw_rate_out)
  );

  // the microprogram must never restart the rotator mid-rotation
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cordic_start |-> !cordic_busy)
    else $error("rotator restarted while busy");

  // sine and cosine are only taken once the rotator has finished
  a_capture_done: assert property (@(posedge clk) disable iff (rst)
    cw.capture |-> !cordic_busy)
    else $error("rotator output captured while busy");

  // a new result only appears after the hand-over step
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cw.emit))
    else $error("result appeared without a hand-over step");

  // a freshly taken tick cannot be handed over on the next step
  a_no_early_emit: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !cw.emit)
    else $error("hand-over directly after an input transfer");

endmodule

FILE: test/planar_odometry_integrator_tb.sv
// self-checking testbench for the planar odometry integrator: directed, random and drive-to-limit ticks
module planar_odometry_integrator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CORDIC_STEPS = poi_pkg::CORDIC_ITERATIONS_DEFAULT;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     QUIET_LIMIT  = 2000;
  localparam int     TAIL_CYCLES  = 50;
  localparam longint POS_MAX      = 64'sh7FFF_FFFF;
  localparam longint POS_MIN      = -64'sh8000_0000;
  localparam longint ONE_Q30      = 64'sd1073741824;
  localparam longint CORDIC_START = 64'sd652032874;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [23:0] yaw_rate;
  } pose_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] vel_x = '0;
  logic signed [15:0] vel_y = '0;
  logic signed [23:0] yaw_rate = '0;
  logic [19:0]        elapsed = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [15:0]        heading_out;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  logic signed [15:0] vel_x_scaled;
  logic signed [15:0] vel_y_out;
  logic signed [23:0] yaw_rate_out;

  // predictor state
  longint      track_x = 0;
  longint      track_y = 0;
  logic [15:0] track_heading = '0;
  logic [15:0] gain_q412 = poi_pkg::GAIN_RESET;

  pose_t expected_poses[$];
  int    fail_count = 0;
  int    quiet_cycles = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  logic  rx_hold = 1'b0;
  event  rx_hold_start;

  planar_odometry_integrator i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .vel_x        (vel_x),
    .vel_y        (vel_y),
    .yaw_rate     (yaw_rate),
    .elapsed      (elapsed),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .heading_out  (heading_out),
    .quat_z       (quat_z),
    .quat_w       (quat_w),
    .vel_x_scaled (vel_x_scaled),
    .vel_y_out    (vel_y_out),
    .yaw_rate_out (yaw_rate_out)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // add one half, then floor
  function automatic longint round_sh(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // arctangent of 2^-i, 2^32 per turn
  function automatic longint arctan_q32(input int i);
    case (i)
      0:  return 536870912;
      1:  return 316933406;
      2:  return 167458907;
      3:  return 85004756;
      4:  return 42667331;
      5:  return 21354465;
      6:  return 10679838;
      7:  return 5340245;
      8:  return 2670163;
      9:  return 1335087;
      10: return 667544;
      11: return 333772;
      12: return 166886;
      13: return 83443;
      14: return 41722;
      15: return 20861;
      16: return 10430;
      17: return 5215;
      18: return 2608;
      19: return 1304;
      20: return 652;
      21: return 326;
      22: return 163;
      default: return 81;
    endcase
  endfunction

  // cosine and sine of a 32-bit binary angle in Q2.30
  function automatic void rotate_q30(input logic [31:0] ang, output longint cos_v,
                                     output longint sin_v);
    logic [31:0] a;
    logic        flip;
    longint      x, y, z, xs, ys;
    a = ang;
    // fold the left half-plane over by a half turn
    flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
    if (flip) a = a + 32'h8000_0000;
    z = longint'($signed(a));
    x = CORDIC_START;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - arctan_q32(i);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + arctan_q32(i);
      end
    end
    x = clamp(x, -ONE_Q30, ONE_Q30);
    y = clamp(y, -ONE_Q30, ONE_Q30);
    if (flip) begin
      x = -x;
      y = -y;
    end
    cos_v = x;
    sin_v = y;
  endfunction

  // dead-reckoning step: moves the tracked pose on by one tick and returns the result
  function automatic pose_t advance_pose(input logic signed [15:0] vx,
                                         input logic signed [15:0] vy,
                                         input logic signed [23:0] wz,
                                         input logic [19:0] dt);
    pose_t       p;
    longint      vx_l, vy_l, wz_l, dt_l, gain_l, vxs, c, s, vw, hstep;
    logic [31:0] a32;
    vx_l   = vx;
    vy_l   = vy;
    wz_l   = wz;
    dt_l   = dt;
    gain_l = gain_q412;
    vxs = clamp(round_sh(vx_l * gain_l, 12), -32768, 32767);
    // position uses the heading from before this tick
    rotate_q30({track_heading, 16'h0000}, c, s);
    vw = round_sh(vxs * c - vy_l * s, 24);
    track_x = clamp(track_x + round_sh(vw * dt_l, 20), POS_MIN, POS_MAX);
    vw = round_sh(vxs * s + vy_l * c, 24);
    track_y = clamp(track_y + round_sh(vw * dt_l, 20), POS_MIN, POS_MAX);
    hstep = round_sh(wz_l * dt_l, 20);
    track_heading = track_heading + 16'(hstep);
    a32 = {track_heading, 16'h0000};
    rotate_q30(a32 >> 1, c, s);
    p.pos_x    = 32'(track_x);
    p.pos_y    = 32'(track_y);
    p.heading  = track_heading;
    p.quat_z   = 16'(clamp(round_sh(s, 15), -32768, 32767));
    p.quat_w   = 16'(clamp(round_sh(c, 15), -32768, 32767));
    p.vel_x    = 16'(vxs);
    p.vel_y    = vy;
    p.yaw_rate = wz;
    return p;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_pose();
    pose_t want;
    if (expected_poses.size() == 0) begin
      $error("pose transfer with no tick outstanding");
      fail_count++;
    end else begin
      want = expected_poses.pop_front();
      check_field("pos_x", want.pos_x, pos_x);
      check_field("pos_y", want.pos_y, pos_y);
      check_field("heading_out", want.heading, heading_out);
      check_field("quat_z", want.quat_z, quat_z);
      check_field("quat_w", want.quat_w, quat_w);
      check_field("vel_x_scaled", want.vel_x, vel_x_scaled);
      check_field("vel_y_out", want.vel_y, vel_y_out);
      check_field("yaw_rate_out", want.yaw_rate, yaw_rate_out);
    end
  endtask

  // receiving side: checks each pose transfer and stalls at random
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_pose();
    out_stall <= rx_hold || ($urandom_range(99) < recv_stall_pct);
  end

  // long receiver hold-off, counted here so the sender keeps offering ticks meanwhile
  always @(rx_hold_start) begin
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("planar_odometry_integrator test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  task automatic send_tick(input logic signed [15:0] vx, input logic signed [15:0] vy,
                           input logic signed [23:0] wz, input logic [19:0] dt);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(50, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    vel_x    <= vx;
    vel_y    <= vy;
    yaw_rate <= wz;
    elapsed  <= dt;
    do @(posedge clk); while (in_stall);
    expected_poses.push_back(advance_pose(vx, vy, wz, dt));
  endtask

  task automatic drain_poses();
    in_valid <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // only written with the block idle
  task automatic write_gain(input logic [15:0] g);
    drain_poses();
    cfg_write <= 1'b1;
    cfg_data  <= g;
    @(posedge clk);
    cfg_write <= 1'b0;
    gain_q412 = g;
  endtask

  task automatic random_tick();
    logic [19:0] dt;
    case ($urandom_range(7))
      0:       dt = '0;
      1:       dt = 20'hFFFFF;
      2:       dt = 20'($urandom_range(255));
      default: dt = 20'($urandom);
    endcase
    send_tick(16'($urandom), 16'($urandom), 24'($urandom), dt);
  endtask

  task automatic test_directed();
    set_idle(0, 0);
    send_tick(16'h0000, 16'h0000, 24'h000000, 20'h00000);  // at rest: w stays at one
    send_tick(16'h7FFF, 16'h0000, 24'h000000, 20'hFFFFF);  // gain overflow upwards
    // quarter turns through every quadrant, the last one wrapping to zero
    repeat (4) send_tick(16'd1000, 16'd500, 24'd16384, 20'hFFFFF);
    send_tick(16'h8000, 16'h8000, 24'h800000, 20'hFFFFF);
    send_tick(16'h7FFF, 16'h7FFF, 24'h7FFFFF, 20'hFFFFF);
    send_tick(16'h7FFF, 16'h8000, 24'h000001, 20'h00001);
    send_tick(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 20'h00001);
    send_tick(16'h0001, 16'h0001, 24'h000000, 20'h80000);
    send_tick(16'h1234, 16'hEDCC, 24'h3A5C96, 20'h00000);  // zero elapsed holds the pose
    send_tick(16'h0000, 16'h0000, 24'h000000, 20'h00000);
    send_tick(16'd100, 16'hFF9C, 24'd8192, 20'hFFFFF);
    send_tick(16'hFF9C, 16'd100, 24'hFFE000, 20'hFFFFF);
    drain_poses();
    // walk the heading to exactly zero, then step across the wrap both ways
    send_tick(16'h0000, 16'h0000, 24'($signed(-track_heading)), 20'hFFFFF);
    send_tick(16'h0000, 16'h0000, 24'hFFFFFF, 20'hFFFFF);
    send_tick(16'h0000, 16'h0000, 24'h000001, 20'hFFFFF);
  endtask

  task automatic test_gain_extremes();
    write_gain(16'h0000);
    send_tick(16'h7FFF, 16'h0100, 24'h000100, 20'hFFFFF);
    send_tick(16'h8000, 16'h0000, 24'h000000, 20'h40000);
    write_gain(16'hFFFF);
    send_tick(16'h8000, 16'h0000, 24'h000000, 20'h10000);
    send_tick(16'h0001, 16'h0000, 24'h000000, 20'h10000);
    send_tick(16'hFFFF, 16'h0000, 24'h000000, 20'h10000);
    send_tick(16'h7FFF, 16'h0000, 24'h000000, 20'h10000);
    write_gain(16'h1000);
    repeat (2) random_tick();
  endtask

  task automatic test_random_mix();
    for (int m = 0; m < 3; m++) begin
      case ($urandom_range(3))
        0:       write_gain(16'h0000);
        1:       write_gain(16'hFFFF);
        default: write_gain(16'($urandom));
      endcase
      case (m)
        0:       set_idle(16, 68);
        1:       set_idle(68, 16);
        default: set_idle(0, 0);
      endcase
      repeat (50) random_tick();
    end
  endtask

  task automatic test_backpressure();
    write_gain(16'($urandom));
    set_idle(0, 0);
    -> rx_hold_start;
    repeat (8) random_tick();
    drain_poses();
    repeat (6) random_tick();
  endtask

  // steer onto a diagonal and hold full speed until one position axis hits its limit
  task automatic test_long_drive();
    logic [15:0]        target;
    logic signed [15:0] turn;
    logic               resteer;
    write_gain(16'hFFFF);
    target  = 16'h2000 + 16'(16384 * $urandom_range(3));
    resteer = 1'b1;
    for (int n = 0; n < 850; n++) begin
      if (n == 0) set_idle(16, 68);
      else if (n == 283) set_idle(68, 16);
      else if (n == 566) set_idle(0, 0);
      if (resteer) begin
        turn = target - track_heading;
        send_tick(16'($urandom_range(64)), 16'($urandom_range(64)), 24'(turn), 20'hFFFFF);
        resteer = 1'b0;
      end else if ($urandom_range(39) == 0) begin
        random_tick();
        resteer = 1'b1;
      end else begin
        send_tick(16'($urandom_range(32767, 30000)), 16'(-$urandom_range(32768, 32000)),
                  24'($urandom_range(128) - 64), 20'($urandom_range(1048575, 1040000)));
        resteer = ($urandom_range(79) == 0);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_gain_extremes();
    test_random_mix();
    test_backpressure();
    test_long_drive();
    drain_poses();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("planar_odometry_integrator test passed");
    end else begin
      $display("planar_odometry_integrator test failed");
    end
    $finish;
  end

endmodule
